### design/bol_pkg.sv
// bol_pkg: shared types, codes and sizes for the bounded ordered list
// used by bol_store, bol_seq and bounded_ordered_list; no dependencies
`default_nettype none

package bol_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CMP_W       = ((CNT_W > 5) ? CNT_W : 5) + 2;

	// operation codes
	localparam logic [2:0] FN_CLEAR     = 3'd0;
	localparam logic [2:0] FN_INS_FRONT = 3'd1;
	localparam logic [2:0] FN_INS_AT    = 3'd2;
	localparam logic [2:0] FN_INS_END   = 3'd3;
	localparam logic [2:0] FN_REMOVE    = 3'd4;
	localparam logic [2:0] FN_SEARCH    = 3'd5;
	localparam logic [2:0] FN_DUMP      = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [2:0]         func;
		logic [4:0]         position;
		logic signed [31:0] code;
		logic [31:0]        height_bits;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         found_position;
		logic signed [31:0] out_code;
		logic [31:0]        out_height_bits;
		logic [4:0]         entry_total;
		logic               last;
	} res_t;

	typedef struct packed {
		logic signed [31:0] code;
		logic [31:0]        height;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

### design/bol_store.sv
// bol_store: record storage, one write and one registered read per cycle
// depends on bol_pkg
`default_nettype none

module bol_store (
	input  wire logic              clk,
	input  wire bol_pkg::mem_req_t mem,
	output bol_pkg::entry_t        rd_data
);
	import bol_pkg::*;

	entry_t slot_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			slot_q[mem.wr_addr] <= mem.wr_data;
		end
		if (mem.rd_en) begin
			rd_data_q <= slot_q[mem.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/bol_seq.sv
// bol_seq: operation sequencer, walks the store one entry per step
// depends on bol_pkg; drives bol_store through a mem_req_t
`default_nettype none

module bol_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire bol_pkg::req_t   req,
	output logic                 busy,
	output bol_pkg::mem_req_t    mem,
	input  wire bol_pkg::entry_t rd_data,
	input  wire logic            res_ready,
	output logic                 res_push,
	output bol_pkg::res_t        res_data
);
	import bol_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DUMP_RD,
		S_DUMP_EMIT,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   fill_q;
	logic [2:0]         func_q;
	logic signed [31:0] code_q;
	logic [31:0]        height_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   tgt_q;
	logic [IDX_W-1:0]   end_q;
	logic [2:0]         status_q;
	logic [4:0]         fpos_q;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] fill_x;
	logic [CMP_W-1:0] dump_n;
	logic [CNT_W-1:0] idx_inc;
	logic [IDX_W-1:0] ins_tgt;
	logic             full;
	logic             is_remove;
	logic             res_valid;

	assign pos_x     = CMP_W'(req.position);
	assign fill_x    = CMP_W'(fill_q);
	assign dump_n    = (fill_x > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : fill_x;
	assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign is_remove = (func_q == FN_REMOVE);
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		case (req.func)
			FN_INS_FRONT: ins_tgt = '0;
			FN_INS_AT:    ins_tgt = IDX_W'(pos_x - CMP_W'(1));
			default:      ins_tgt = IDX_W'(fill_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q   <= req.func;
						code_q   <= req.code;
						height_q <= req.height_bits;
						status_q <= ST_OK;
						fpos_q   <= '0;
						state_q  <= S_RESP;
						unique case (req.func) inside
							FN_CLEAR: begin
								fill_q <= '0;
							end
							FN_INS_FRONT, FN_INS_AT, FN_INS_END: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (req.func == FN_INS_AT &&
										(pos_x == '0 || pos_x > fill_x + CMP_W'(1))) begin
									status_q <= ST_BADPOS;
								end else begin
									tgt_q <= ins_tgt;
									if (CMP_W'(ins_tgt) == fill_x) begin
										state_q <= S_PLACE;
									end else begin
										idx_q   <= IDX_W'(fill_q - CNT_W'(1));
										state_q <= S_SHIFT_RD;
									end
								end
							end
							FN_REMOVE: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
								end else if (pos_x == '0 || pos_x > fill_x) begin
									status_q <= ST_BADPOS;
								end else if (pos_x == fill_x) begin
									// tail entry, nothing to move
									fill_q <= fill_q - CNT_W'(1);
								end else begin
									idx_q   <= IDX_W'(pos_x - CMP_W'(1));
									state_q <= S_SHIFT_RD;
								end
							end
							FN_SEARCH: begin
								status_q <= ST_NOTFOUND;
								if (fill_q != '0) begin
									idx_q   <= '0;
									end_q   <= IDX_W'(fill_q - CNT_W'(1));
									state_q <= S_SRCH_RD;
								end
							end
							FN_DUMP: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									idx_q   <= '0;
									end_q   <= IDX_W'(dump_n - CMP_W'(1));
									state_q <= S_DUMP_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (is_remove) begin
						if (CMP_W'(idx_q) + CMP_W'(2) == fill_x) begin
							fill_q  <= fill_q - CNT_W'(1);
							state_q <= S_RESP;
						end else begin
							idx_q   <= IDX_W'(idx_inc);
							state_q <= S_SHIFT_RD;
						end
					end else if (idx_q == tgt_q) begin
						state_q <= S_PLACE;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= S_SHIFT_RD;
					end
				end
				S_PLACE: begin
					fill_q  <= fill_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (rd_data.code == code_q) begin
						status_q <= ST_OK;
						fpos_q   <= 5'(idx_inc);
						state_q  <= S_RESP;
					end else if (idx_q == end_q) begin
						state_q <= S_RESP;
					end else begin
						idx_q   <= IDX_W'(idx_inc);
						state_q <= S_SRCH_RD;
					end
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_EMIT;
				end
				S_DUMP_EMIT: begin
					if (res_ready) begin
						if (idx_q == end_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= IDX_W'(idx_inc);
							state_q <= S_DUMP_RD;
						end
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// store port
	always_comb begin
		mem.rd_en   = (state_q == S_SHIFT_RD) || (state_q == S_SRCH_RD) ||
			(state_q == S_DUMP_RD);
		mem.rd_addr = (state_q == S_SHIFT_RD && is_remove) ? IDX_W'(idx_inc) : idx_q;
		mem.wr_en   = (state_q == S_SHIFT_WR) || (state_q == S_PLACE);
		if (state_q == S_PLACE) begin
			mem.wr_addr      = tgt_q;
			mem.wr_data.code   = code_q;
			mem.wr_data.height = height_q;
		end else begin
			mem.wr_addr = is_remove ? idx_q : IDX_W'(idx_inc);
			mem.wr_data = rd_data;
		end
	end

	// result
	always_comb begin
		res_valid = (state_q == S_RESP) || (state_q == S_DUMP_EMIT);
		res_push  = res_valid && res_ready;
		res_data.entry_total = 5'(fill_q);
		if (state_q == S_DUMP_EMIT) begin
			res_data.status          = ST_OK;
			res_data.found_position  = '0;
			res_data.out_code        = rd_data.code;
			res_data.out_height_bits = rd_data.height;
			res_data.last            = (idx_q == end_q);
		end else begin
			res_data.status          = status_q;
			res_data.found_position  = fpos_q;
			res_data.out_code        = '0;
			res_data.out_height_bits = '0;
			res_data.last            = 1'b1;
		end
	end

endmodule

`default_nettype wire

### design/bounded_ordered_list.sv
// bounded_ordered_list: top level, sequencer, record store and result register
// depends on bol_pkg, bol_store and bol_seq
`default_nettype none

// Ordered list of up to DEPTH records (signed code plus 32-bit height), kept
// packed in a store with one write port and one registered read port. A
// request is taken when req_valid is high and req_stall low; req_stall stays
// high while an operation runs and until its last result has been loaded
// into the result register. Every entry that moves or is looked at takes a
// state to read the store and then a state to write, compare or emit it.
// Clear, rejected requests and unused codes go straight to the result. A
// dump waits while res_stall holds the result register. There is no clearing
// pass: entries above the fill count are never read, so the store needs no
// reset.
module bounded_ordered_list (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bol_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_stall,
	output bol_pkg::res_t      res
);
	import bol_pkg::*;

	mem_req_t mem;
	entry_t   rd_data;
	logic     busy;
	logic     res_ready;
	logic     res_push;
	res_t     res_data;
	logic     res_valid_q;
	res_t     res_q;

	// sequencer owns the list order and the fill count
	bol_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.busy      (busy),
		.mem       (mem),
		.rd_data   (rd_data),
		.res_ready (res_ready),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// record slots
	bol_store u_store (
		.clk     (clk),
		.mem     (mem),
		.rd_data (rd_data)
	);

	// result register: frees the sequencer as soon as a result is parked
	assign res_ready = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
			res_q       <= res_data;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// no new request until the current one has handed off its last result
	assign req_stall = busy;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### tb/sv/bounded_ordered_list_tb.sv
`timescale 1ns / 1ps
// bounded_ordered_list_tb: self-checking bench for the bounded ordered list,
// a list model predicts every result; needs bol_pkg and bounded_ordered_list
module bounded_ordered_list_tb;

	import bol_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 60;

	// a request as queued for the driver: optionally held back until the
	// block has delivered everything owed so far
	typedef struct packed {
		logic drain_first;
		req_t r;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	bounded_ordered_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted list contents, advanced once per accepted request
	logic signed [31:0] list_code [DEPTH];
	logic [31:0]        list_height [DEPTH];
	int                 list_len = 0;

	res_t  due_results[$];
	stim_t ops_to_send[$];
	stim_t next_op;

	int mismatches = 0;
	int accepted_reqs = 0;
	bit req_taken = 1'b0;

	// stimulus-side bookkeeping: entry count as it will be when each queued
	// request reaches the block, and codes worth searching for
	int          gen_len = 0;
	logic [31:0] code_pool[$];

	// sender burst state
	int burst_left = 1;
	int gap_left = 0;

	// receiver stall state
	int       hold_left = 0;
	bit       long_hold_done = 1'b0;
	int       stall_mode = 0;
	int       mode_left = 0;
	bit [7:0] stall_pat = 8'b1011_0010;

	int idle_cycles = 0;

	// list model: applies one request and queues the results it must produce
	function automatic void apply_list_op(input req_t op);
		res_t want;
		int   p;
		int   n;
		int   i;
		bit   hit;
		want = '0;
		want.status = ST_OK;
		want.last = 1'b1;
		p = int'(op.position);
		hit = 1'b0;
		case (op.func)
			FN_CLEAR: begin
				list_len = 0;
			end
			FN_INS_FRONT, FN_INS_AT, FN_INS_END: begin
				if (op.func == FN_INS_FRONT) p = 1;
				if (op.func == FN_INS_END) p = list_len + 1;
				// fullness wins over a bad position
				if (list_len >= DEPTH) begin
					want.status = ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					want.status = ST_BADPOS;
				end else begin
					for (i = list_len; i >= p; i--) begin
						list_code[i] = list_code[i - 1];
						list_height[i] = list_height[i - 1];
					end
					list_code[p - 1] = op.code;
					list_height[p - 1] = op.height_bits;
					list_len++;
				end
			end
			FN_REMOVE: begin
				if (list_len == 0) begin
					want.status = ST_EMPTY;
				end else if (p < 1 || p > list_len) begin
					want.status = ST_BADPOS;
				end else begin
					for (i = p - 1; i + 1 < list_len; i++) begin
						list_code[i] = list_code[i + 1];
						list_height[i] = list_height[i + 1];
					end
					list_len--;
				end
			end
			FN_SEARCH: begin
				// first match wins, reported as a list position
				want.status = ST_NOTFOUND;
				for (i = 0; i < list_len; i++) begin
					if (!hit && list_code[i] == op.code) begin
						hit = 1'b1;
						want.status = ST_OK;
						want.found_position = 5'(i + 1);
					end
				end
			end
			FN_DUMP: begin
				if (list_len == 0) begin
					want.status = ST_EMPTY;
					due_results.push_back(want);
				end else begin
					n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
					for (i = 0; i < n; i++) begin
						want.out_code = list_code[i];
						want.out_height_bits = list_height[i];
						want.entry_total = 5'(list_len);
						want.last = (i == n - 1);
						due_results.push_back(want);
					end
				end
			end
			default: ;
		endcase
		if (op.func != FN_DUMP) begin
			want.entry_total = 5'(list_len);
			due_results.push_back(want);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void next_result_check(input res_t want);
		compare_field("status", want.status, res.status);
		compare_field("found_position", want.found_position, res.found_position);
		compare_field("out_code", want.out_code, res.out_code);
		compare_field("out_height_bits", want.out_height_bits, res.out_height_bits);
		compare_field("entry_total", want.entry_total, res.entry_total);
		compare_field("last", want.last, res.last);
	endfunction

	// queue one request and track the entry count it leaves behind
	task automatic queue_op(input logic [2:0] f, input int p, input logic [31:0] c,
			input logic [31:0] h, input bit drain);
		stim_t s;
		s.drain_first = drain;
		s.r.func = f;
		s.r.position = 5'(p);
		s.r.code = c;
		s.r.height_bits = h;
		ops_to_send.push_back(s);
		case (f)
			FN_CLEAR: gen_len = 0;
			FN_INS_FRONT, FN_INS_END: begin
				if (gen_len < DEPTH) gen_len++;
			end
			FN_INS_AT: begin
				if (gen_len < DEPTH && p >= 1 && p <= gen_len + 1) gen_len++;
			end
			FN_REMOVE: begin
				if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
			end
			default: ;
		endcase
		if (f == FN_INS_FRONT || f == FN_INS_AT || f == FN_INS_END) begin
			code_pool.push_back(c);
			if (code_pool.size() > 64) void'(code_pool.pop_front());
		end
	endtask

	// mostly a legal position in 1..hi, sometimes zero or past the end
	function automatic int pick_position(input int hi);
		if (hi < 1) return $urandom_range(0, 31);
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(hi + 1, 31);
		return $urandom_range(1, hi);
	endfunction

	function automatic logic [31:0] pick_code();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4: return 32'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_height();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// stimulus and end of run
	initial begin
		logic [31:0] c;
		bit          growing;
		int          pick;
		int          n;
		int          total_ops;

		// directed: empty-list corner cases first
		queue_op(FN_DUMP, 0, 0, 0, 0);
		queue_op(FN_REMOVE, 1, 0, 0, 0);
		queue_op(FN_SEARCH, 0, 0, 0, 0);
		queue_op(FN_INS_AT, 0, 32'h1234_5678, 32'h1, 0);
		queue_op(FN_INS_AT, 2, 32'h1234_5678, 32'h1, 0);
		// build a small list with extreme codes and payloads
		queue_op(FN_INS_AT, 1, 32'h8000_0000, 32'h0000_0000, 0);
		queue_op(FN_INS_FRONT, 0, 32'h7fff_ffff, 32'hffff_ffff, 0);
		queue_op(FN_INS_END, 0, 32'hffff_ffff, 32'ha5a5_5a5a, 0);
		// position count+1 appends
		queue_op(FN_INS_AT, 4, 32'h0000_0000, 32'h5a5a_a5a5, 0);
		queue_op(FN_INS_AT, 2, 32'h0000_0005, 32'h0000_0001, 0);
		queue_op(FN_SEARCH, 0, 32'hffff_ffff, 0, 0);
		queue_op(FN_SEARCH, 0, 32'h0001_e240, 0, 0);
		// unused operation code: no change
		queue_op(3'd7, 31, 32'hffff_ffff, 32'hffff_ffff, 0);
		queue_op(FN_DUMP, 0, 0, 0, 0);
		// bad positions on remove and insert, then tail and front removes and a clear
		queue_op(FN_REMOVE, 0, 0, 0, 0);
		queue_op(FN_REMOVE, 6, 0, 0, 0);
		queue_op(FN_REMOVE, 31, 0, 0, 0);
		queue_op(FN_INS_AT, 31, 32'h0000_0009, 32'h9, 0);
		queue_op(FN_REMOVE, 5, 0, 0, 0);
		queue_op(FN_REMOVE, 1, 0, 0, 0);
		queue_op(FN_CLEAR, 0, 0, 0, 0);
		queue_op(FN_DUMP, 0, 0, 0, 0);
		// removing the only entry leaves the list empty
		queue_op(FN_INS_END, 0, 32'h0000_0042, 32'h42, 0);
		queue_op(FN_REMOVE, 1, 0, 0, 0);
		queue_op(FN_SEARCH, 0, 32'h0000_0042, 0, 0);

		// fill to the top, hit the full case on each kind of insert, dump it all
		for (n = 0; n < DEPTH + 1; n++)
			queue_op(FN_INS_END, 0, pick_code(), pick_height(), n == 0);
		queue_op(FN_INS_FRONT, 0, pick_code(), pick_height(), 0);
		queue_op(FN_INS_AT, 0, pick_code(), pick_height(), 0);
		queue_op(FN_DUMP, 0, 0, 0, 0);
		queue_op(FN_SEARCH, 0, code_pool[code_pool.size() - 1], 0, 0);
		queue_op(FN_REMOVE, DEPTH, 0, 0, 0);
		queue_op(FN_REMOVE, 1, 0, 0, 0);

		// random: grow and shrink phases picked at random so the list sweeps its
		// whole range, searches mostly aimed at codes that were inserted
		growing = 1'b1;
		for (n = 0; n < 400; n++) begin
			if (n % 50 == 0) growing = $urandom_range(0, 1);
			pick = $urandom_range(0, 99);
			if (pick < (growing ? 55 : 25)) begin
				case ($urandom_range(0, 2))
					0: queue_op(FN_INS_FRONT, $urandom_range(0, 31), pick_code(),
						pick_height(), n % 100 == 0);
					1: queue_op(FN_INS_AT, pick_position(gen_len + 1), pick_code(),
						pick_height(), n % 100 == 0);
					default: queue_op(FN_INS_END, $urandom_range(0, 31), pick_code(),
						pick_height(), n % 100 == 0);
				endcase
			end else if (pick < (growing ? 70 : 65)) begin
				queue_op(FN_REMOVE, pick_position(gen_len), $urandom, $urandom,
					n % 100 == 0);
			end else if (pick < 85) begin
				if (code_pool.size() != 0 && $urandom_range(0, 9) < 7)
					c = code_pool[$urandom_range(0, code_pool.size() - 1)];
				else
					c = pick_code();
				queue_op(FN_SEARCH, $urandom_range(0, 31), c, $urandom, n % 100 == 0);
			end else if (pick < 95) begin
				queue_op(FN_DUMP, $urandom_range(0, 31), $urandom, $urandom, n % 100 == 0);
			end else if (pick < 97) begin
				queue_op(FN_CLEAR, $urandom_range(0, 31), $urandom, $urandom, n % 100 == 0);
			end else begin
				queue_op(3'd7, $urandom_range(0, 31), $urandom, $urandom, n % 100 == 0);
			end
		end
		total_ops = ops_to_send.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// checks at the falling edge so the monitor's updates are settled
		while (accepted_reqs < total_ops) @(negedge clk);
		while (due_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("bounded_ordered_list_tb passed");
		else
			$display("bounded_ordered_list_tb failed");
		$finish;
	end

	// driver: bursts of requests with random gaps; a held request keeps its
	// payload until taken, and a marked request waits for the block to drain
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (ops_to_send.size() == 0 ||
					(ops_to_send[0].drain_first && due_results.size() != 0)) begin
				req_valid <= 1'b0;
			end else begin
				next_op = ops_to_send.pop_front();
				req <= next_op.r;
				req_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// some bursts run straight into the next with no gap
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
	end

	// receiver: one long hold-off once the run is under way, otherwise
	// stretches of no stall, coin-flip stall, a rotating pattern, or rare stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!long_hold_done && accepted_reqs >= 120) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 1) == 1);
				2: begin
					res_stall <= stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[7:1]};
				end
				default: res_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// monitor: predict on every accepted request, compare every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				apply_list_op(req);
				accepted_reqs++;
				req_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$error("result with nothing pending: status %0d code 0x%0h last %0b",
						res.status, res.out_code, res.last);
					mismatches++;
				end else begin
					next_result_check(due_results.pop_front());
				end
			end
		end
	end

	// watchdog: too long with neither side moving ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("bounded_ordered_list_tb failed");
			$finish;
		end
	end

endmodule

### filelist.f
design/bol_pkg.sv
design/bol_store.sv
design/bol_seq.sv
design/bounded_ordered_list.sv
tb/sv/bounded_ordered_list_tb.sv
